### rtl/text_terminal_scrollback_engine_defines.svh
// ---------------------------------------------------------------------------
// text terminal scrollback engine assertion macros
// shared concurrent assertion forms, clocked and disabled during reset
// ---------------------------------------------------------------------------
`ifndef TEXT_TERMINAL_SCROLLBACK_ENGINE_DEFINES_SVH
`define TEXT_TERMINAL_SCROLLBACK_ENGINE_DEFINES_SVH

// same-cycle implication
`define TTS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TTS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/tts_pkg.sv
// ---------------------------------------------------------------------------
// tts_pkg
// shared opcodes, command kinds and beat formats of the scrollback engine
// ---------------------------------------------------------------------------
package tts_pkg;

    // input opcodes
    typedef enum logic [1:0] {
        OP_PUT   = 2'd0,
        OP_READ  = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NONE  = 2'd3
    } t_opcode;

    // configuration register indexes
    localparam int CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] CFG_FG = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_BG = 1'b1;
    localparam int CFG_DATA_W = 4;

    // reset colors
    localparam logic [3:0] FG_RESET = 4'd7;
    localparam logic [3:0] BG_RESET = 4'd0;

    // character classes
    localparam logic [7:0] CHAR_LINE_FEED = 8'd10;
    localparam logic [7:0] CHAR_FIRST     = 8'd32;
    localparam logic [7:0] CHAR_LAST      = 8'd126;

    // grey-on-black space written by a line feed
    localparam logic [15:0] BLANK_CELL = 16'h0720;

    // classified command kinds
    typedef enum logic [2:0] {
        K_NOP       = 3'd0,
        K_PRINT     = 3'd1,
        K_ADVANCE   = 3'd2,
        K_LINE_FEED = 3'd3,
        K_READ      = 3'd4,
        K_CLEAR     = 3'd5
    } t_kind;

    // command beat from front to back
    typedef struct packed {
        t_kind       kind;
        logic [15:0] cell_data;
        logic [4:0]  read_row;
        logic [6:0]  read_column;
    } t_cmd;

    // result beat
    typedef struct packed {
        logic [15:0] cell_entry;
        logic [6:0]  cursor_column;
        logic [4:0]  cursor_screen_row;
        logic [5:0]  scroll_shift;
    } t_result;

endpackage

### rtl/tts_ram.sv
// ---------------------------------------------------------------------------
// tts_ram
// generic single-port ram with registered read
// ---------------------------------------------------------------------------
module tts_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 5120
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/tts_fifo.sv
// ---------------------------------------------------------------------------
// tts_fifo
// small register queue with push/full and pop/empty sides
// ---------------------------------------------------------------------------
module tts_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int PW = $clog2(DEPTH);
    localparam int NW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr, n_wr;
    logic [PW-1:0]    r_rd, n_rd;
    logic [NW-1:0]    r_cnt, n_cnt;
    logic             w_push;
    logic             w_pop;

    assign o_full  = (r_cnt == NW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    // pointer and count update
    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (w_push) begin
            n_wr = (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (w_pop) begin
            n_rd = (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (w_push && !w_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (w_pop && !w_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    // payload storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

### rtl/tts_front.sv
// ---------------------------------------------------------------------------
// tts_front
// color registers and classification of input beats into commands
// ---------------------------------------------------------------------------
module tts_front
    import tts_pkg::*;
#(
    parameter int COLUMNS = 80
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  logic [1:0]             i_opcode,
    input  logic [7:0]             i_char_code,
    input  logic [4:0]             i_read_row,
    input  logic [6:0]             i_read_column,
    output t_cmd                   o_cmd
);

    logic [3:0] r_fg;
    logic [3:0] r_bg;
    logic       w_printable;
    logic       w_col_ok;

    // color registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fg <= FG_RESET;
            r_bg <= BG_RESET;
        end else if (i_cfg_we) begin
            priority if (i_cfg_index == CFG_FG) begin
                r_fg <= i_cfg_data;
            end else begin
                r_bg <= i_cfg_data;
            end
        end
    end

    assign w_printable = (i_char_code >= CHAR_FIRST) && (i_char_code <= CHAR_LAST);
    assign w_col_ok    = (8'(i_read_column) < 8'(COLUMNS));

    // classify the beat
    always_comb begin
        o_cmd.cell_data   = {r_bg, r_fg, i_char_code};
        o_cmd.read_row    = i_read_row;
        o_cmd.read_column = i_read_column;
        unique case (t_opcode'(i_opcode))
            OP_PUT: begin
                priority if (i_char_code == CHAR_LINE_FEED) begin
                    o_cmd.kind = K_LINE_FEED;
                end else if (w_printable) begin
                    o_cmd.kind = K_PRINT;
                end else begin
                    o_cmd.kind = K_ADVANCE;
                end
            end
            // a column past the row reads as zero
            OP_READ:  o_cmd.kind = w_col_ok ? K_READ : K_NOP;
            OP_CLEAR: o_cmd.kind = K_CLEAR;
            OP_NONE:  o_cmd.kind = K_NOP;
        endcase
    end

endmodule

### rtl/tts_back.sv
// ---------------------------------------------------------------------------
// tts_back
// executes commands against the cell ram, cursor and row valid bits
// ---------------------------------------------------------------------------
`include "text_terminal_scrollback_engine_defines.svh"

module tts_back
    import tts_pkg::*;
#(
    parameter int COLUMNS     = 80,
    parameter int SCREEN_ROWS = 25,
    parameter int RING_ROWS   = 64
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cmd    i_cmd,
    input  logic    i_cmd_valid,
    output logic    o_cmd_pop,
    input  logic    i_res_full,
    output logic    o_res_push,
    output t_result o_res
);

    localparam int CW = $clog2(COLUMNS);
    localparam int SW = $clog2(SCREEN_ROWS);
    localparam int RW = $clog2(RING_ROWS);
    localparam int AW = $clog2(RING_ROWS * COLUMNS);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_SWEEP = 3'b010,
        S_READ  = 3'b100
    } t_state;

    t_state                 r_state, n_state;
    logic [RW-1:0]          r_ring, n_ring;
    logic [CW-1:0]          r_col, n_col;
    logic [SW-1:0]          r_srow, n_srow;
    logic [RW-1:0]          r_top, n_top;
    logic [RING_ROWS-1:0]   r_row_valid, n_row_valid;
    logic [AW-1:0]          r_sweep_base, n_sweep_base;
    logic [CW-1:0]          r_sweep_col, n_sweep_col;
    logic                   r_fill_blank, n_fill_blank;
    logic                   r_final, n_final;

    logic                   w_ram_we;
    logic                   w_ram_re;
    logic [AW-1:0]          w_ram_addr;
    logic [15:0]            w_ram_wdata;
    logic [15:0]            w_ram_rdata;
    logic [15:0]            w_res_cell;
    logic [RW:0]            w_sum;
    logic [RW:0]            w_sum1;
    logic [RW:0]            w_sum2;
    logic [RW-1:0]          w_rd_row;
    logic [RW-1:0]          w_ring_next;
    logic                   w_start;
    logic                   w_advance;
    logic                   w_line_feed;

    function automatic logic [AW-1:0] row_base(input logic [RW-1:0] row);
        row_base = AW'(row) * AW'(COLUMNS);
    endfunction

    // screen row to ring row, top plus row folded back at most twice
    assign w_sum  = (RW+1)'(r_top) + (RW+1)'(i_cmd.read_row);
    assign w_sum1 = (w_sum >= (RW+1)'(RING_ROWS)) ? w_sum - (RW+1)'(RING_ROWS) : w_sum;
    assign w_sum2 = (w_sum1 >= (RW+1)'(RING_ROWS)) ? w_sum1 - (RW+1)'(RING_ROWS) : w_sum1;
    assign w_rd_row = RW'(w_sum2);

    assign w_ring_next = (r_ring == RW'(RING_ROWS - 1)) ? '0 : r_ring + 1'b1;
    assign w_start     = (r_state == S_IDLE) && i_cmd_valid && !i_res_full;

    // command sequencer
    always_comb begin
        n_state      = r_state;
        n_ring       = r_ring;
        n_col        = r_col;
        n_srow       = r_srow;
        n_top        = r_top;
        n_row_valid  = r_row_valid;
        n_sweep_base = r_sweep_base;
        n_sweep_col  = r_sweep_col;
        n_fill_blank = r_fill_blank;
        n_final      = r_final;
        w_ram_we     = 1'b0;
        w_ram_re     = 1'b0;
        w_ram_addr   = '0;
        w_ram_wdata  = '0;
        w_res_cell   = '0;
        o_cmd_pop    = 1'b0;
        o_res_push   = 1'b0;
        w_advance    = 1'b0;
        w_line_feed  = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (w_start) begin
                    unique case (i_cmd.kind)
                        K_CLEAR: begin
                            n_row_valid = '0;
                            o_cmd_pop   = 1'b1;
                            o_res_push  = 1'b1;
                        end
                        K_READ: begin
                            o_cmd_pop = 1'b1;
                            if (r_row_valid[w_rd_row]) begin
                                w_ram_re   = 1'b1;
                                w_ram_addr = row_base(w_rd_row)
                                           + AW'(i_cmd.read_column[CW-1:0]);
                                n_state    = S_READ;
                            end else begin
                                o_res_push = 1'b1;
                            end
                        end
                        K_PRINT: begin
                            if (!r_row_valid[r_ring]) begin
                                // row never filled: zero it, then retry the put
                                n_sweep_base        = row_base(r_ring);
                                n_sweep_col         = '0;
                                n_fill_blank        = 1'b0;
                                n_final             = 1'b0;
                                n_row_valid[r_ring] = 1'b1;
                                n_state             = S_SWEEP;
                            end else begin
                                w_ram_we    = 1'b1;
                                w_ram_addr  = row_base(r_ring) + AW'(r_col);
                                w_ram_wdata = i_cmd.cell_data;
                                w_advance   = 1'b1;
                            end
                        end
                        K_ADVANCE:   w_advance   = 1'b1;
                        K_LINE_FEED: w_line_feed = 1'b1;
                        default: begin
                            o_cmd_pop  = 1'b1;
                            o_res_push = 1'b1;
                        end
                    endcase
                end
            end
            S_SWEEP: begin
                w_ram_we    = 1'b1;
                w_ram_addr  = r_sweep_base + AW'(r_sweep_col);
                w_ram_wdata = r_fill_blank ? BLANK_CELL : 16'd0;
                if (r_sweep_col == CW'(COLUMNS - 1)) begin
                    n_state    = S_IDLE;
                    o_res_push = r_final;
                end else begin
                    n_sweep_col = r_sweep_col + 1'b1;
                end
            end
            S_READ: begin
                w_res_cell = w_ram_rdata;
                o_res_push = 1'b1;
                n_state    = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase

        // column step, wrapping into a line feed
        if (w_advance) begin
            if (r_col == CW'(COLUMNS - 1)) begin
                w_line_feed = 1'b1;
            end else begin
                n_col      = r_col + 1'b1;
                o_cmd_pop  = 1'b1;
                o_res_push = 1'b1;
            end
        end

        // line feed: next ring row, cursor or view moves, blank sweep follows
        if (w_line_feed) begin
            n_ring                   = w_ring_next;
            n_col                    = '0;
            if (r_srow == SW'(SCREEN_ROWS - 1)) begin
                n_top = (r_top == RW'(RING_ROWS - 1)) ? '0 : r_top + 1'b1;
            end else begin
                n_srow = r_srow + 1'b1;
            end
            n_sweep_base             = row_base(w_ring_next);
            n_sweep_col              = '0;
            n_fill_blank             = 1'b1;
            n_final                  = 1'b1;
            n_row_valid[w_ring_next] = 1'b1;
            n_state                  = S_SWEEP;
            o_cmd_pop                = 1'b1;
        end
    end

    // result beat reflects the state after the item
    assign o_res.cell_entry        = w_res_cell;
    assign o_res.cursor_column     = 7'(n_col);
    assign o_res.cursor_screen_row = 5'(n_srow);
    assign o_res.scroll_shift      = 6'(n_top);

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ring      <= '0;
            r_col       <= '0;
            r_srow      <= '0;
            r_top       <= '0;
            r_row_valid <= '0;
            r_sweep_col <= '0;
            r_final     <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ring      <= n_ring;
            r_col       <= n_col;
            r_srow      <= n_srow;
            r_top       <= n_top;
            r_row_valid <= n_row_valid;
            r_sweep_col <= n_sweep_col;
            r_final     <= n_final;
        end
    end

    // sweep payload
    always_ff @(posedge i_clk) begin
        r_sweep_base <= n_sweep_base;
        r_fill_blank <= n_fill_blank;
    end

    // cell store
    tts_ram #(
        .WIDTH (16),
        .DEPTH (RING_ROWS * COLUMNS)
    ) u_cells (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_re    (w_ram_re),
        .i_addr  (w_ram_addr),
        .i_wdata (w_ram_wdata),
        .o_rdata (w_ram_rdata)
    );

    // checks
    `TTS_ASSERT_IMP(a_port_excl, i_clk, i_rst_n, w_ram_we, !w_ram_re, "ram read and write together")
    `TTS_ASSERT_IMP(a_read_filled, i_clk, i_rst_n, w_ram_re, r_row_valid[w_rd_row], "read of unfilled row")
    `TTS_ASSERT_IMP(a_push_room, i_clk, i_rst_n, o_res_push, !i_res_full, "result push while full")
    `TTS_ASSERT_NXT(a_clear_all, i_clk, i_rst_n, w_start && (i_cmd.kind == K_CLEAR), r_row_valid == '0, "clear left rows valid")

endmodule

### rtl/text_terminal_scrollback_engine.sv
// put, clear and no-op push their result beat as they are taken, a read from S_READ after
// the registered ram read, and a line feed or column wrap at the end of the blank sweep of
// the new row through the ram port; first put to a row after reset or clear is held behind a
// zero sweep of that row; back end holds one item and takes the next only when back in idle
// synchronous active-low reset empties the queues, clears the row valid bits so the
// whole store reads as zero at once, and restores colors fg 7 and bg 0
// ---------------------------------------------------------------------------
// text_terminal_scrollback_engine
// text terminal over a ring of character rows with screen-relative reads
// ---------------------------------------------------------------------------
module text_terminal_scrollback_engine
    import tts_pkg::*;
#(
    parameter int COLUMNS     = 80,
    parameter int SCREEN_ROWS = 25,
    parameter int RING_ROWS   = 64
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                   push,
    output logic                   full,
    input  logic [1:0]             i_opcode,
    input  logic [7:0]             i_char_code,
    input  logic [4:0]             i_read_row,
    input  logic [6:0]             i_read_column,
    output logic                   empty,
    input  logic                   pop,
    output logic [15:0]            o_cell_entry,
    output logic [6:0]             o_cursor_column,
    output logic [4:0]             o_cursor_screen_row,
    output logic [5:0]             o_scroll_shift
);

    localparam int QUEUE_DEPTH = 2;

    t_cmd    w_cmd_in;
    t_cmd    w_cmd_out;
    logic    w_cmd_empty;
    logic    w_cmd_pop;
    t_result w_res_in;
    t_result w_res_out;
    logic    w_res_full;
    logic    w_res_push;

    // classification and colors
    tts_front #(
        .COLUMNS (COLUMNS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_opcode      (i_opcode),
        .i_char_code   (i_char_code),
        .i_read_row    (i_read_row),
        .i_read_column (i_read_column),
        .o_cmd         (w_cmd_in)
    );

    // command queue between front and back
    tts_fifo #(
        .WIDTH ($bits(t_cmd)),
        .DEPTH (QUEUE_DEPTH)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (w_cmd_in),
        .o_full  (full),
        .i_pop   (w_cmd_pop),
        .o_data  (w_cmd_out),
        .o_empty (w_cmd_empty)
    );

    // execution
    tts_back #(
        .COLUMNS     (COLUMNS),
        .SCREEN_ROWS (SCREEN_ROWS),
        .RING_ROWS   (RING_ROWS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd_out),
        .i_cmd_valid (!w_cmd_empty),
        .o_cmd_pop   (w_cmd_pop),
        .i_res_full  (w_res_full),
        .o_res_push  (w_res_push),
        .o_res       (w_res_in)
    );

    // result queue
    tts_fifo #(
        .WIDTH ($bits(t_result)),
        .DEPTH (QUEUE_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_data  (w_res_in),
        .o_full  (w_res_full),
        .i_pop   (pop),
        .o_data  (w_res_out),
        .o_empty (empty)
    );

    assign o_cell_entry        = w_res_out.cell_entry;
    assign o_cursor_column     = w_res_out.cursor_column;
    assign o_cursor_screen_row = w_res_out.cursor_screen_row;
    assign o_scroll_shift      = w_res_out.scroll_shift;

endmodule

### verif/text_terminal_scrollback_engine_test.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// text_terminal_scrollback_engine_test
// self-checking bench: a directed pass over field extremes and corner cases,
// then random text lines, scroll bursts, reads, clears and noise under three
// idle mixes, each result beat compared against an untimed terminal model
// ---------------------------------------------------------------------------
module text_terminal_scrollback_engine_test;
    import tts_pkg::*;

    localparam int COLUMNS         = 80;
    localparam int SCREEN_ROWS     = 25;
    localparam int RING_ROWS       = 64;
    localparam int STORE_CELLS     = RING_ROWS * COLUMNS;
    localparam int CYCLE_LIMIT     = 1_500_000;
    localparam int DRAIN_CYCLES    = 2 * COLUMNS + 8;
    localparam int ITEMS_PER_PHASE = 530;
    localparam int MAX_PRINTED     = 100;

    // untimed terminal model plus the queue of beats it predicts
    class scrollback_board;
        logic [15:0] cells [STORE_CELLS];
        int unsigned ring_row;
        int unsigned cursor_col;
        int unsigned screen_row;
        int unsigned top_shift;
        logic [3:0]  fg;
        logic [3:0]  bg;
        t_result     expected_q [$];
        int unsigned errors;

        function new();
            clear_cells();
            ring_row   = 0;
            cursor_col = 0;
            screen_row = 0;
            top_shift  = 0;
            fg         = FG_RESET;
            bg         = BG_RESET;
            errors     = 0;
        endfunction

        function void clear_cells();
            foreach (cells[i]) cells[i] = 16'h0000;
        endfunction

        function void set_color(logic [CFG_INDEX_W-1:0] index, logic [3:0] data);
            if (index == CFG_FG) fg = data;
            else bg = data;
        endfunction

        // next ring row, blanked; cursor moves down or the view scrolls
        function void line_feed();
            ring_row   = (ring_row + 1) % RING_ROWS;
            cursor_col = 0;
            for (int i = 0; i < COLUMNS; i++) cells[ring_row * COLUMNS + i] = BLANK_CELL;
            if (screen_row + 1 < SCREEN_ROWS) screen_row++;
            else top_shift = (top_shift + 1) % RING_ROWS;
        endfunction

        function void put_char(logic [7:0] ch);
            int unsigned row;
            if (ch == CHAR_LINE_FEED) begin
                line_feed();
                return;
            end
            if (ch >= CHAR_FIRST && ch <= CHAR_LAST) begin
                row = (top_shift + screen_row) % RING_ROWS;
                cells[row * COLUMNS + cursor_col] = {bg, fg, ch};
            end
            cursor_col++;
            if (cursor_col >= COLUMNS) line_feed();
        endfunction

        // accepted input beat: advance the model and queue its result
        function void note_input(t_opcode op, logic [7:0] ch, logic [4:0] rr, logic [6:0] rc);
            t_result want;
            int unsigned row;
            want.cell_entry = 16'h0000;
            case (op)
                OP_PUT: begin
                    put_char(ch);
                end
                OP_READ: begin
                    row = (top_shift + rr) % RING_ROWS;
                    if (rc < COLUMNS) want.cell_entry = cells[row * COLUMNS + rc];
                end
                OP_CLEAR: begin
                    clear_cells();
                end
                default: ;
            endcase
            want.cursor_column     = 7'(cursor_col);
            want.cursor_screen_row = 5'(screen_row);
            want.scroll_shift      = 6'(top_shift);
            expected_q.push_back(want);
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        task report(string what, logic [15:0] got, logic [15:0] want);
            errors++;
            if (errors <= MAX_PRINTED)
                $display("[%0t] %s mismatch: got 0x%0h, expected 0x%0h", $time, what, got, want);
        endtask

        // accepted result beat against the oldest prediction
        task check_result(logic [15:0] cell_val, logic [6:0] col, logic [4:0] row,
                          logic [5:0] shift);
            t_result want;
            if (expected_q.size() == 0) begin
                report("unexpected result beat, cell_entry", cell_val, 16'h0000);
                return;
            end
            want = expected_q.pop_front();
            if (cell_val !== want.cell_entry) report("cell_entry", cell_val, want.cell_entry);
            if (col !== want.cursor_column)
                report("cursor_column", 16'(col), 16'(want.cursor_column));
            if (row !== want.cursor_screen_row)
                report("cursor_screen_row", 16'(row), 16'(want.cursor_screen_row));
            if (shift !== want.scroll_shift)
                report("scroll_shift", 16'(shift), 16'(want.scroll_shift));
        endtask
    endclass

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] i_cfg_index = CFG_FG;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;
    logic                   push = 1'b0;
    logic                   full;
    logic [1:0]             i_opcode = OP_NONE;
    logic [7:0]             i_char_code = '0;
    logic [4:0]             i_read_row = '0;
    logic [6:0]             i_read_column = '0;
    logic                   empty;
    logic                   pop = 1'b0;
    logic [15:0]            o_cell_entry;
    logic [6:0]             o_cursor_column;
    logic [4:0]             o_cursor_screen_row;
    logic [5:0]             o_scroll_shift;

    scrollback_board board;
    int unsigned     send_idle_pct = 25;
    int unsigned     recv_idle_pct = 61;
    int unsigned     items_sent = 0;
    int unsigned     cycles = 0;

    text_terminal_scrollback_engine #(
        .COLUMNS     (COLUMNS),
        .SCREEN_ROWS (SCREEN_ROWS),
        .RING_ROWS   (RING_ROWS)
    ) dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .push                (push),
        .full                (full),
        .i_opcode            (i_opcode),
        .i_char_code         (i_char_code),
        .i_read_row          (i_read_row),
        .i_read_column       (i_read_column),
        .empty               (empty),
        .pop                 (pop),
        .o_cell_entry        (o_cell_entry),
        .o_cursor_column     (o_cursor_column),
        .o_cursor_screen_row (o_cursor_screen_row),
        .o_scroll_shift      (o_scroll_shift)
    );

    always #6 i_clk = ~i_clk;

    // run limit
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // result side: random pop, check every accepted beat
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (pop && !empty)
                board.check_result(o_cell_entry, o_cursor_column, o_cursor_screen_row,
                                   o_scroll_shift);
            pop <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // one input beat, with a random gap ahead of it; push stays high into the next beat
    task automatic send_item(t_opcode op, logic [7:0] ch, logic [4:0] rr, logic [6:0] rc);
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push          <= 1'b1;
        i_opcode      <= op;
        i_char_code   <= ch;
        i_read_row    <= rr;
        i_read_column <= rc;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        board.note_input(op, ch, rr, rc);
        if (op != OP_NONE) items_sent++;
    endtask

    task automatic send_put(logic [7:0] ch);
        send_item(OP_PUT, ch, 5'($urandom), 7'($urandom));
    endtask

    task automatic send_read(logic [4:0] rr, logic [6:0] rc);
        send_item(OP_READ, 8'($urandom), rr, rc);
    endtask

    // color write once every predicted beat is back
    task automatic write_color(logic [CFG_INDEX_W-1:0] index, logic [3:0] data);
        push <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        board.set_color(index, data);
    endtask

    // random traffic built mostly from text lines and scroll bursts
    task automatic run_random(int unsigned target);
        int unsigned kind;
        logic [7:0]  ch;
        t_opcode     op;
        while (items_sent < target) begin
            kind = $urandom_range(99);
            if (kind < 40) begin
                // text line, long ones wrap, with stray unprintable bytes
                repeat ($urandom_range(1, 95)) begin
                    if ($urandom_range(9) == 0) begin
                        do ch = 8'($urandom);
                        while (ch == CHAR_LINE_FEED || (ch >= CHAR_FIRST && ch <= CHAR_LAST));
                    end else begin
                        ch = 8'($urandom_range(CHAR_FIRST, CHAR_LAST));
                    end
                    send_put(ch);
                end
                if ($urandom_range(9) < 7) send_put(CHAR_LINE_FEED);
            end else if (kind < 62) begin
                // reads: cursor row, visible screen, anywhere
                repeat ($urandom_range(1, 8)) begin
                    if ($urandom_range(1) == 1)
                        send_read(5'(board.screen_row), 7'($urandom_range(COLUMNS - 1)));
                    else if ($urandom_range(3) != 0)
                        send_read(5'($urandom_range(SCREEN_ROWS - 1)),
                                  7'($urandom_range(COLUMNS - 1)));
                    else
                        send_read(5'($urandom), 7'($urandom));
                end
            end else if (kind < 75) begin
                // scroll burst
                repeat ($urandom_range(1, 30)) send_put(CHAR_LINE_FEED);
            end else if (kind < 95) begin
                // noise with raw fields
                repeat ($urandom_range(1, 4)) begin
                    op = t_opcode'($urandom_range(3));
                    if (op == OP_CLEAR) op = OP_NONE;
                    send_item(op, 8'($urandom), 5'($urandom), 7'($urandom));
                end
            end else if (kind < 98) begin
                send_item(OP_CLEAR, 8'($urandom), 5'($urandom), 7'($urandom));
            end else begin
                send_item(OP_NONE, 8'($urandom), 5'($urandom), 7'($urandom));
            end
        end
    endtask

    initial begin
        board = new();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset store, printable edges, unprintable bytes, read bounds
        send_read(5'd0, 7'd0);
        send_put(8'd65);
        send_put(CHAR_FIRST);
        send_put(CHAR_LAST);
        send_put(8'd31);
        send_put(8'd127);
        send_put(8'd255);
        send_put(8'd0);
        send_read(5'd0, 7'd0);
        send_read(5'd0, 7'd2);
        send_read(5'd0, 7'd79);
        send_read(5'd0, 7'd80);
        send_read(5'd24, 7'd127);
        send_put(CHAR_LINE_FEED);
        send_read(5'd1, 7'd0);
        send_read(5'd31, 7'd5);
        send_read(5'd25, 7'd0);
        send_item(OP_NONE, 8'hFF, 5'h1F, 7'h7F);
        send_item(OP_CLEAR, 8'h00, 5'h00, 7'h00);
        send_read(5'd1, 7'd0);
        send_put(8'd122);
        send_read(5'd1, 7'd0);

        // sender idles less than receiver
        write_color(CFG_FG, 4'hF);
        write_color(CFG_BG, 4'h0);
        run_random(ITEMS_PER_PHASE);

        // receiver idles less than sender
        write_color(CFG_FG, 4'h0);
        write_color(CFG_BG, 4'hF);
        send_idle_pct = 61;
        recv_idle_pct = 25;
        run_random(2 * ITEMS_PER_PHASE);

        // back to back on both sides
        write_color(CFG_FG, 4'($urandom));
        write_color(CFG_BG, 4'($urandom));
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(3 * ITEMS_PER_PHASE);

        // drain
        push <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (board.errors == 0 && board.pending() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
